// File: hdl/dbn_pkg.sv
// ----------------------------------------------------------------------------
// dbn_pkg: shared types and constants
// Payload structs, register indexes, reset values and fixed arithmetic
// constants of the box decode and suppression block.
// ----------------------------------------------------------------------------
package dbn_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] score;
        logic        last_candidate;
    } t_cand;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] width_px;
        logic [11:0] height_px;
        logic [15:0] kept_score;
        logic        valid_res;
        logic        overflow;
        logic        last;
    } t_res;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 3'd6;

    localparam logic [23:0] RST_INV_SCALE   = 24'd65536;
    localparam logic [11:0] RST_FRAME       = 12'd640;
    localparam logic [15:0] RST_SCORE_THR   = 16'd16384;
    localparam logic [15:0] RST_OVERLAP_THR = 16'd26214;

    // scaling divides by 320*65536 = 5 * 2^22: shift by 22, then
    // multiply by ceil(2^27/5) and shift by 27 (exact below 2^26)
    localparam int unsigned QW       = 23;
    localparam logic [24:0] RECIP_K5 = 25'd26843546;

    localparam int unsigned MIN_SIDE = 5;

endpackage

// File: hdl/dbn_cand_if.sv
// ----------------------------------------------------------------------------
// dbn_cand_if: candidate channel
// Valid/ready channel carrying one raw detector candidate per transfer.
// ----------------------------------------------------------------------------
interface dbn_cand_if;
    logic          valid;
    logic          ready;
    dbn_pkg::t_cand data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dbn_res_if.sv
// ----------------------------------------------------------------------------
// dbn_res_if: result channel
// Valid/ready channel carrying one kept box per transfer.
// ----------------------------------------------------------------------------
interface dbn_res_if;
    logic         valid;
    logic         ready;
    dbn_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dbn_ram.sv
// ----------------------------------------------------------------------------
// dbn_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dbn_ram #(
    parameter int unsigned W = 64,
    parameter int unsigned D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/dbn_mul.sv
// ----------------------------------------------------------------------------
// dbn_mul: shared multiplier
// Unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module dbn_mul #(
    parameter int unsigned W = 25
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    logic [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: hdl/detection_box_decode_nms.sv
// ----------------------------------------------------------------------------
// detection_box_decode_nms: box decode and greedy IoU suppression
//
//   channel   dir  handshake            payload
//   i_cand    in   valid/ready          center, size, score, last_candidate
//   o_res     out  valid/ready          box, score, valid_res, overflow, last
//   i_cfg_*   in   write enable only    register index, write data
//
// Sequence: a candidate under the score threshold is accepted and dropped. A
// passing candidate is decoded (4 values, each through the multiply, divide
// and save steps on the shared multiplier, then a clamp) and inserted by a
// sorted walk that shifts each stored box with a lower score up by one slot.
// After the last candidate, suppression reads each unsuppressed box and
// compares it with every later unsuppressed box on the multiplier; then each
// unsuppressed box is read back and emitted, and suppressed boxes are skipped.
// The shared multiplier and the one-read-port box RAM serialize these steps.
// Reset clears control state, flags and count; the box RAM is not cleared
// (only entries below the count are read). i_cand is ready only when idle;
// a stalled result holds the sequencer in its wait state.
// ----------------------------------------------------------------------------
module detection_box_decode_nms #(
    parameter int unsigned MAX_KEPT   = 32,
    parameter int unsigned FRAME_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dbn_cand_if.sink                         i_cand,
    dbn_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [dbn_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_KEPT);
    localparam int unsigned CW = $clog2(MAX_KEPT + 1);
    localparam int unsigned FB = FRAME_BITS;
    localparam int unsigned EW = 4 * FB + 16;
    localparam int unsigned UW = 2 * FB + 1;
    localparam int unsigned MW = (UW > 25) ? UW : 25;
    localparam int unsigned QW = dbn_pkg::QW;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_DMUL = 20'h00002,
        S_DDIV = 20'h00004,
        S_DSAV = 20'h00008,
        S_DCHK = 20'h00010,
        S_IRD  = 20'h00020,
        S_ICMP = 20'h00040,
        S_NI   = 20'h00080,
        S_NIA  = 20'h00100,
        S_NJ   = 20'h00200,
        S_NJB  = 20'h00400,
        S_NM1  = 20'h00800,
        S_NM2  = 20'h01000,
        S_NM3  = 20'h02000,
        S_NM4  = 20'h04000,
        S_NM5  = 20'h08000,
        S_NM6  = 20'h10000,
        S_ERD  = 20'h20000,
        S_ELD  = 20'h40000,
        S_EWT  = 20'h80000
    } t_state;

    // configuration
    logic [11:0] r_offx, r_offy;
    logic [23:0] r_scale;
    logic [FB-1:0] r_fw, r_fh;
    logic [15:0] r_score_thr, r_ovl_thr;

    // control
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_i, n_i, r_j, n_j;
    logic [1:0] r_k, n_k;
    logic r_ovf, n_ovf;
    logic [MAX_KEPT-1:0] r_flag, n_flag;
    logic r_ovalid, n_ovalid;

    // payload
    dbn_pkg::t_cand r_cand, n_cand;
    logic r_neg, n_neg;
    logic [QW-1:0] r_dec [4];
    logic [QW-1:0] n_dec [4];
    logic [EW-1:0] r_new, n_new, r_a, n_a;
    logic [FB:0] r_iw, n_iw, r_ih, n_ih;
    logic [2*FB-1:0] r_inter, n_inter;
    logic [UW-1:0] r_uni, n_uni;
    dbn_pkg::t_res r_res, n_res;

    // shared multiplier and box store
    logic [MW-1:0] mul_a, mul_b;
    logic [2*MW-1:0] mul_p;
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    dbn_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dbn_ram #(.W(EW), .D(MAX_KEPT)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---- decode operands: corners and sizes in 1/320 model pixel ----
    logic signed [17:0] cx, cy;
    logic signed [23:0] vx, vy, vw, vh, v_sel;

    assign cx = $signed({2'b00, r_cand.center_x}) - $signed({2'b00, r_offx, 4'b0000});
    assign cy = $signed({2'b00, r_cand.center_y}) - $signed({2'b00, r_offy, 4'b0000});
    assign vx = $signed({{6{cx[17]}}, cx}) * 24'sd20 - $signed({8'd0, r_cand.box_w}) * 24'sd11;
    assign vy = $signed({{6{cy[17]}}, cy}) * 24'sd20 - $signed({8'd0, r_cand.box_h}) * 24'sd11;
    assign vw = $signed({8'd0, r_cand.box_w}) * 24'sd22;
    assign vh = $signed({8'd0, r_cand.box_h}) * 24'sd22;

    always_comb begin
        unique case (r_k)
            2'd0:    v_sel = vx;
            2'd1:    v_sel = vy;
            2'd2:    v_sel = vw;
            default: v_sel = vh;
        endcase
    end

    // ---- clamp to frame ----
    logic [FB-1:0] fwm1, fhm1, xc, yc, wlim, hlim, wc, hc;
    logic box_ok;

    assign fwm1 = r_fw - FB'(1);
    assign fhm1 = r_fh - FB'(1);
    assign xc   = (r_dec[0] > QW'(fwm1)) ? fwm1 : r_dec[0][FB-1:0];
    assign yc   = (r_dec[1] > QW'(fhm1)) ? fhm1 : r_dec[1][FB-1:0];
    assign wlim = r_fw - xc;
    assign hlim = r_fh - yc;
    assign wc   = (r_dec[2] > QW'(wlim)) ? wlim : r_dec[2][FB-1:0];
    assign hc   = (r_dec[3] > QW'(hlim)) ? hlim : r_dec[3][FB-1:0];
    assign box_ok = (r_fw != '0) && (r_fh != '0) &&
                    (wc > FB'(dbn_pkg::MIN_SIDE)) && (hc > FB'(dbn_pkg::MIN_SIDE));

    // ---- stored entry fields: score | h | w | y | x ----
    logic [FB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic [15:0] rd_score, new_score;
    logic [FB:0] ea_x, ea_y, eb_x, eb_y, ix0, ix1, iy0, iy1;

    assign ax = r_a[FB-1:0];
    assign ay = r_a[2*FB-1:FB];
    assign aw = r_a[3*FB-1:2*FB];
    assign ah = r_a[4*FB-1:3*FB];
    assign bx = ram_rdata[FB-1:0];
    assign by = ram_rdata[2*FB-1:FB];
    assign bw = ram_rdata[3*FB-1:2*FB];
    assign bh = ram_rdata[4*FB-1:3*FB];
    assign rd_score  = ram_rdata[EW-1:4*FB];
    assign new_score = r_new[EW-1:4*FB];

    assign ea_x = (FB+1)'(ax) + (FB+1)'(aw);
    assign ea_y = (FB+1)'(ay) + (FB+1)'(ah);
    assign eb_x = (FB+1)'(bx) + (FB+1)'(bw);
    assign eb_y = (FB+1)'(by) + (FB+1)'(bh);
    assign ix0  = (ax > bx) ? (FB+1)'(ax) : (FB+1)'(bx);
    assign iy0  = (ay > by) ? (FB+1)'(ay) : (FB+1)'(by);
    assign ix1  = (ea_x < eb_x) ? ea_x : eb_x;
    assign iy1  = (ea_y < eb_y) ? ea_y : eb_y;

    // any unsuppressed stored box after position r_i
    logic more;
    always_comb begin
        more = 1'b0;
        for (int m = 0; m < MAX_KEPT; m++) begin
            if ((CW'(m) > r_i) && (CW'(m) < r_count) && !r_flag[m]) begin
                more = 1'b1;
            end
        end
    end

    logic [CW-1:0] jm1;
    logic [2*MW-1:0] inter_sh;
    assign jm1 = r_j - CW'(1);
    assign inter_sh = (2*MW)'({r_inter, 16'd0});

    // ---- sequencer ----
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_ovf    = r_ovf;
        n_flag   = r_flag;
        n_ovalid = r_ovalid;
        n_cand   = r_cand;
        n_neg    = r_neg;
        n_dec    = r_dec;
        n_new    = r_new;
        n_a      = r_a;
        n_iw     = r_iw;
        n_ih     = r_ih;
        n_inter  = r_inter;
        n_uni    = r_uni;
        n_res    = r_res;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_new;
        ram_raddr = r_i[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cand.valid) begin
                    n_cand = i_cand.data;
                    n_k    = 2'd0;
                    if (i_cand.data.score < r_score_thr) begin
                        if (i_cand.data.last_candidate) begin
                            n_i     = '0;
                            n_state = S_NI;
                        end
                    end else begin
                        n_state = S_DMUL;
                    end
                end
            end
            S_DMUL: begin
                mul_a   = MW'(v_sel[22:0]);
                mul_b   = MW'(r_scale);
                n_neg   = v_sel[23];
                n_state = S_DDIV;
            end
            S_DDIV: begin
                mul_a   = MW'(mul_p[46:22]);
                mul_b   = MW'(dbn_pkg::RECIP_K5);
                n_state = S_DSAV;
            end
            S_DSAV: begin
                // a negative corner truncates to at most zero, so it clamps to 0
                n_dec[r_k] = r_neg ? '0 : mul_p[49:27];
                n_k        = r_k + 2'd1;
                n_state    = (r_k == 2'd3) ? S_DCHK : S_DMUL;
            end
            S_DCHK: begin
                if (!box_ok) begin
                    n_state = r_cand.last_candidate ? S_NI : S_IDLE;
                    n_i     = '0;
                end else if (r_count == CW'(MAX_KEPT)) begin
                    n_ovf   = 1'b1;
                    n_state = r_cand.last_candidate ? S_NI : S_IDLE;
                    n_i     = '0;
                end else begin
                    n_new   = {r_cand.score, hc, wc, yc, xc};
                    n_j     = r_count;
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                // insertion walk: shift lower scores up by one slot
                if (r_j == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    n_count   = r_count + CW'(1);
                    n_i       = '0;
                    n_state   = r_cand.last_candidate ? S_NI : S_IDLE;
                end else begin
                    ram_raddr = jm1[AW-1:0];
                    n_state   = S_ICMP;
                end
            end
            S_ICMP: begin
                ram_we = 1'b1;
                if (rd_score < new_score) begin
                    ram_wdata = ram_rdata;
                    n_j       = jm1;
                    n_state   = S_IRD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_i     = '0;
                    n_state = r_cand.last_candidate ? S_NI : S_IDLE;
                end
            end
            S_NI: begin
                if (r_i >= r_count) begin
                    n_i = '0;
                    if (r_count == '0) begin
                        n_res    = '0;
                        n_res.overflow = r_ovf;
                        n_res.last     = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_EWT;
                    end else begin
                        n_state = S_ERD;
                    end
                end else if (r_flag[r_i[AW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    ram_raddr = r_i[AW-1:0];
                    n_state   = S_NIA;
                end
            end
            S_NIA: begin
                n_a     = ram_rdata;
                n_j     = r_i + CW'(1);
                n_state = S_NJ;
            end
            S_NJ: begin
                if (r_j >= r_count) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_NI;
                end else if (r_flag[r_j[AW-1:0]]) begin
                    n_j = r_j + CW'(1);
                end else begin
                    ram_raddr = r_j[AW-1:0];
                    n_state   = S_NJB;
                end
            end
            S_NJB: begin
                n_new   = ram_rdata;
                n_iw    = (ix1 > ix0) ? (ix1 - ix0) : '0;
                n_ih    = (iy1 > iy0) ? (iy1 - iy0) : '0;
                n_state = S_NM1;
            end
            S_NM1: begin
                mul_a   = MW'(r_iw);
                mul_b   = MW'(r_ih);
                n_state = S_NM2;
            end
            S_NM2: begin
                n_inter = mul_p[2*FB-1:0];
                mul_a   = MW'(aw);
                mul_b   = MW'(ah);
                n_state = S_NM3;
            end
            S_NM3: begin
                n_uni   = UW'(mul_p[2*FB-1:0]);
                mul_a   = MW'(r_new[3*FB-1:2*FB]);
                mul_b   = MW'(r_new[4*FB-1:3*FB]);
                n_state = S_NM4;
            end
            S_NM4: begin
                n_uni   = r_uni + UW'(mul_p[2*FB-1:0]) - UW'(r_inter);
                n_state = S_NM5;
            end
            S_NM5: begin
                mul_a   = MW'(r_uni);
                mul_b   = MW'(r_ovl_thr);
                n_state = S_NM6;
            end
            S_NM6: begin
                if (inter_sh > mul_p) begin
                    n_flag[r_j[AW-1:0]] = 1'b1;
                end
                n_j     = r_j + CW'(1);
                n_state = S_NJ;
            end
            S_ERD: begin
                if (r_flag[r_i[AW-1:0]]) begin
                    n_i = r_i + CW'(1);
                end else begin
                    ram_raddr = r_i[AW-1:0];
                    n_state   = S_ELD;
                end
            end
            S_ELD: begin
                n_res.left       = 12'(bx);
                n_res.top        = 12'(by);
                n_res.width_px   = 12'(bw);
                n_res.height_px  = 12'(bh);
                n_res.kept_score = rd_score;
                n_res.valid_res  = 1'b1;
                n_res.overflow   = r_ovf;
                n_res.last       = !more;
                n_ovalid         = 1'b1;
                n_state          = S_EWT;
            end
            S_EWT: begin
                if (o_res.ready) begin
                    n_ovalid = 1'b0;
                    if (r_res.last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_flag  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_ovf    <= 1'b0;
            r_flag   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_ovf    <= n_ovf;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_neg   <= n_neg;
        r_dec   <= n_dec;
        r_new   <= n_new;
        r_a     <= n_a;
        r_iw    <= n_iw;
        r_ih    <= n_ih;
        r_inter <= n_inter;
        r_uni   <= n_uni;
        r_res   <= n_res;
    end

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offx      <= '0;
            r_offy      <= '0;
            r_scale     <= dbn_pkg::RST_INV_SCALE;
            r_fw        <= FB'(dbn_pkg::RST_FRAME);
            r_fh        <= FB'(dbn_pkg::RST_FRAME);
            r_score_thr <= dbn_pkg::RST_SCORE_THR;
            r_ovl_thr   <= dbn_pkg::RST_OVERLAP_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dbn_pkg::CFG_OFFSET_X:    r_offx      <= i_cfg_data[11:0];
                dbn_pkg::CFG_OFFSET_Y:    r_offy      <= i_cfg_data[11:0];
                dbn_pkg::CFG_INV_SCALE:   r_scale     <= i_cfg_data;
                dbn_pkg::CFG_FRAME_W:     r_fw        <= FB'(i_cfg_data[11:0]);
                dbn_pkg::CFG_FRAME_H:     r_fh        <= FB'(i_cfg_data[11:0]);
                dbn_pkg::CFG_SCORE_THR:   r_score_thr <= i_cfg_data[15:0];
                dbn_pkg::CFG_OVERLAP_THR: r_ovl_thr   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign i_cand.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.data   = r_res;

`ifndef NO_ASSERTIONS
    // the highest-scoring box is never suppressed
    a_top_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flag[0])
        else $error("top-ranked box marked suppressed");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEPT))
        else $error("box count above capacity");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cand.ready && o_res.valid))
        else $error("candidate taken while a result is pending");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.data.last)
            |=> (r_count == '0 && r_flag == '0 && !r_ovf))
        else $error("frame state not cleared after last result");

    a_valid_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.valid_res)
            |-> (o_res.data.width_px > 12'd5 || FB > 12))
        else $error("emitted box narrower than minimum");
`endif
endmodule

// File: bench/dbn_scoreboard.sv
// ----------------------------------------------------------------------------
// dbn_scoreboard: box decode and suppression scoreboard
// Watches candidate, result and register traffic, predicts the kept boxes
// of each frame and compares every result field against the prediction.
// ----------------------------------------------------------------------------
module dbn_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dbn_cand_if                            cand,
    dbn_res_if                             res,
    input  logic                           i_cfg_we,
    input  logic [dbn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STORE_DEPTH = 32;
    localparam longint SCALE_DIV = 64'd320 * 64'd65536;

    typedef struct {
        longint      x, y, w, h;
        int unsigned sc;
    } t_box;

    // register shadow
    logic [11:0] offs_x, offs_y, frame_w, frame_h;
    logic [23:0] scale_q16;
    logic [15:0] score_thr, overlap_thr;

    t_box          frame_boxes[$];
    bit            overflow_seen;
    dbn_pkg::t_res expected_boxes[$];
    int            fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_boxes.size();

    task automatic report(string what, longint exp_v, longint got_v);
        $display("[%0t] %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
        fails++;
    endtask

    function automatic longint scale_to_frame(longint v320);
        return (v320 * longint'(scale_q16)) / SCALE_DIV;
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic bit boxes_overlap(t_box a, t_box b);
        longint ix0, iy0, ix1, iy1, inter, uni;
        ix0 = lmax(a.x, b.x);
        iy0 = lmax(a.y, b.y);
        ix1 = lmin(a.x + a.w, b.x + b.w);
        iy1 = lmin(a.y + a.h, b.y + b.h);
        inter = 0;
        if (ix1 > ix0 && iy1 > iy0) inter = (ix1 - ix0) * (iy1 - iy0);
        uni = a.w * a.h + b.w * b.h - inter;
        return inter * 65536 > longint'(overlap_thr) * uni;
    endfunction

    task automatic decode_candidate(dbn_pkg::t_cand c);
        longint cx, cy, bw, bh;
        t_box   b;
        cx = longint'(c.center_x) - 16 * longint'(offs_x);
        cy = longint'(c.center_y) - 16 * longint'(offs_y);
        bw = longint'(c.box_w);
        bh = longint'(c.box_h);
        if (c.score < score_thr) return;
        b.x = scale_to_frame(20 * cx - 11 * bw);
        b.y = scale_to_frame(20 * cy - 11 * bh);
        b.w = scale_to_frame(22 * bw);
        b.h = scale_to_frame(22 * bh);
        b.x = lmax(0, lmin(b.x, longint'(frame_w) - 1));
        b.y = lmax(0, lmin(b.y, longint'(frame_h) - 1));
        b.w = lmin(b.w, longint'(frame_w) - b.x);
        b.h = lmin(b.h, longint'(frame_h) - b.y);
        b.sc = c.score;
        if (!(b.w > longint'(dbn_pkg::MIN_SIDE) && b.h > longint'(dbn_pkg::MIN_SIDE))) return;
        if (frame_boxes.size() >= STORE_DEPTH) begin
            overflow_seen = 1'b1;
            return;
        end
        frame_boxes = {frame_boxes, b};
    endtask

    // sort, suppress and queue the frame's results
    task automatic close_frame();
        t_box          t;
        bit            gone[$];
        int            j, last_keep;
        dbn_pkg::t_res r;
        for (int i = 1; i < frame_boxes.size(); i++) begin
            t = frame_boxes[i];
            j = i;
            // stable: equal scores keep arrival order
            while (j > 0 && frame_boxes[j-1].sc < t.sc) begin
                frame_boxes[j] = frame_boxes[j-1];
                j--;
            end
            frame_boxes[j] = t;
        end
        foreach (frame_boxes[i]) gone = {gone, 1'b0};
        for (int i = 0; i < frame_boxes.size(); i++) begin
            if (gone[i]) continue;
            for (int k = i + 1; k < frame_boxes.size(); k++)
                if (!gone[k] && boxes_overlap(frame_boxes[i], frame_boxes[k]))
                    gone[k] = 1'b1;
        end
        last_keep = -1;
        foreach (frame_boxes[i]) if (!gone[i]) last_keep = i;
        if (last_keep < 0) begin
            r = '0;
            r.overflow = overflow_seen;
            r.last     = 1'b1;
            expected_boxes = {expected_boxes, r};
        end else begin
            for (int i = 0; i <= last_keep; i++) begin
                if (gone[i]) continue;
                r.left       = frame_boxes[i].x[11:0];
                r.top        = frame_boxes[i].y[11:0];
                r.width_px   = frame_boxes[i].w[11:0];
                r.height_px  = frame_boxes[i].h[11:0];
                r.kept_score = frame_boxes[i].sc[15:0];
                r.valid_res  = 1'b1;
                r.overflow   = overflow_seen;
                r.last       = (i == last_keep);
                expected_boxes = {expected_boxes, r};
            end
        end
        frame_boxes.delete();
        overflow_seen = 1'b0;
    endtask

    task automatic compare_result(dbn_pkg::t_res got);
        dbn_pkg::t_res e;
        if (expected_boxes.size() == 0) begin
            report("unexpected result", 0, longint'(64'(got)));
            return;
        end
        e = expected_boxes.pop_front();
        if (got.left != e.left)             report("left", e.left, got.left);
        if (got.top != e.top)               report("top", e.top, got.top);
        if (got.width_px != e.width_px)     report("width_px", e.width_px, got.width_px);
        if (got.height_px != e.height_px)   report("height_px", e.height_px, got.height_px);
        if (got.kept_score != e.kept_score) report("kept_score", e.kept_score, got.kept_score);
        if (got.valid_res != e.valid_res)   report("valid_res", e.valid_res, got.valid_res);
        if (got.overflow != e.overflow)     report("overflow", e.overflow, got.overflow);
        if (got.last != e.last)             report("last", e.last, got.last);
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offs_x      = '0;
            offs_y      = '0;
            scale_q16   = dbn_pkg::RST_INV_SCALE;
            frame_w     = dbn_pkg::RST_FRAME;
            frame_h     = dbn_pkg::RST_FRAME;
            score_thr   = dbn_pkg::RST_SCORE_THR;
            overlap_thr = dbn_pkg::RST_OVERLAP_THR;
            frame_boxes.delete();
            overflow_seen = 1'b0;
        end else begin
            if (res.valid && res.ready) compare_result(res.data);
            if (cand.valid && cand.ready) begin
                decode_candidate(cand.data);
                if (cand.data.last_candidate) close_frame();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dbn_pkg::CFG_OFFSET_X:    offs_x      = i_cfg_data[11:0];
                    dbn_pkg::CFG_OFFSET_Y:    offs_y      = i_cfg_data[11:0];
                    dbn_pkg::CFG_INV_SCALE:   scale_q16   = i_cfg_data[23:0];
                    dbn_pkg::CFG_FRAME_W:     frame_w     = i_cfg_data[11:0];
                    dbn_pkg::CFG_FRAME_H:     frame_h     = i_cfg_data[11:0];
                    dbn_pkg::CFG_SCORE_THR:   score_thr   = i_cfg_data[15:0];
                    dbn_pkg::CFG_OVERLAP_THR: overlap_thr = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: box decode and suppression testbench
// Drives directed and random candidate frames under several register
// settings, with random idling on both channels and one long result stall.
// The scoreboard predicts and checks; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;   // covers decode + insertion of a busy store

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [dbn_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [dbn_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             cycle_count = 0;

    dbn_cand_if cand_ch();
    dbn_res_if  res_ch();

    detection_box_decode_nms dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cand     (cand_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dbn_scoreboard u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cand         (cand_ch),
        .res          (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // stimulus-side copy of the settings, used to aim boxes inside the frame
    int unsigned cur_offx, cur_offy, cur_thr, cur_fw, cur_fh;
    bit          snd_no_idle, rcv_no_idle;
    int          results_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result sink: random stalls, bursts with no stall, one long hold-off
    initial begin
        res_ch.ready  = 1'b0;
        results_taken = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            res_ch.ready = 1'b0;
            // long hold-off early on so the block backs up into its input
            if (results_taken == 3) repeat (800) @(negedge i_clk);
            else if (!rcv_no_idle) repeat ($urandom_range(0, 19)) @(negedge i_clk);
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            results_taken++;
        end
    end

    task automatic write_reg(logic [dbn_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val[dbn_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // wait for every expected result, then let a trailing decode finish
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_regs(int unsigned ox, oy, scl, fw, fh, thr, ovl);
        drain();
        write_reg(dbn_pkg::CFG_OFFSET_X, ox);
        write_reg(dbn_pkg::CFG_OFFSET_Y, oy);
        write_reg(dbn_pkg::CFG_INV_SCALE, scl);
        write_reg(dbn_pkg::CFG_FRAME_W, fw);
        write_reg(dbn_pkg::CFG_FRAME_H, fh);
        write_reg(dbn_pkg::CFG_SCORE_THR, thr);
        write_reg(dbn_pkg::CFG_OVERLAP_THR, ovl);
        cur_offx = ox;
        cur_offy = oy;
        cur_thr  = thr;
        cur_fw   = fw;
        cur_fh   = fh;
        snd_no_idle = ($urandom_range(0, 3) == 0);
        rcv_no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // one candidate transfer; valid stays high across back-to-back items
    task automatic offer(dbn_pkg::t_cand c);
        if (!snd_no_idle) begin
            int gap;
            gap = $urandom_range(0, 19);
            if (gap != 0) begin
                cand_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        cand_ch.valid = 1'b1;
        cand_ch.data  = c;
        do @(posedge i_clk); while (!cand_ch.ready);
        @(negedge i_clk);
        cand_ch.valid = 1'b0;
    endtask

    // box in model pixels (converted to Q12.4), offset added back in
    function automatic dbn_pkg::t_cand model_box(int unsigned cx, cy, w, h, sc, bit last_c);
        dbn_pkg::t_cand c;
        c.center_x       = 16'((cx + cur_offx) * 16);
        c.center_y       = 16'((cy + cur_offy) * 16);
        c.box_w          = 16'(w * 16);
        c.box_h          = 16'(h * 16);
        c.score          = 16'(sc);
        c.last_candidate = last_c;
        return c;
    endfunction

    // random frames: mostly clustered boxes, some noise and sub-threshold items
    task automatic random_frames(int n_items);
        int             sent, len, kind;
        int unsigned    clu_x[3], clu_y[3], prev_sc, sc, k;
        dbn_pkg::t_cand c;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
            foreach (clu_x[i]) begin
                clu_x[i] = $urandom_range(0, (cur_fw > 40) ? cur_fw : 40);
                clu_y[i] = $urandom_range(0, (cur_fh > 40) ? cur_fh : 40);
            end
            prev_sc = 65535;
            for (int i = 0; i < len; i++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    c.center_x = 16'($urandom);
                    c.center_y = 16'($urandom);
                    c.box_w    = 16'($urandom);
                    c.box_h    = 16'($urandom);
                    c.score    = 16'($urandom);
                end else begin
                    k  = $urandom_range(0, 2);
                    sc = (kind == 1) ? $urandom_range(0, 65535)
                       : ($urandom_range(0, 4) == 0) ? prev_sc
                       : $urandom_range(cur_thr, 65535);
                    c = model_box(clu_x[k] + $urandom_range(0, 12),
                                  clu_y[k] + $urandom_range(0, 12),
                                  $urandom_range(4, ($urandom_range(0, 9) == 0) ? 1500 : 120),
                                  $urandom_range(4, 120), sc, 1'b0);
                    prev_sc = sc;
                end
                c.last_candidate = (i == len - 1);
                offer(c);
                sent++;
            end
        end
    endtask

    initial begin
        dbn_pkg::t_cand c;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = dbn_pkg::CFG_OFFSET_X;
        cfg_data      = '0;
        cand_ch.valid = 1'b0;
        cand_ch.data  = '0;
        cur_offx = 0;  cur_offy = 0;  cur_thr = dbn_pkg::RST_SCORE_THR;
        cur_fw = dbn_pkg::RST_FRAME;  cur_fh = dbn_pkg::RST_FRAME;
        snd_no_idle = 1'b0;
        rcv_no_idle = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings: duplicates, score ties, threshold edge
        offer(model_box(100, 100, 50, 40, 60000, 1'b0));
        offer(model_box(100, 100, 50, 40, 50000, 1'b0));   // suppressed twin
        offer(model_box(300, 300, 30, 30, 50000, 1'b0));   // tie with the twin
        offer(model_box(302, 301, 30, 30, 16384, 1'b0));   // exactly at threshold
        offer(model_box(500, 500, 20, 20, 16383, 1'b0));   // just below
        offer(model_box(200, 200, 2, 40, 65535, 1'b0));    // too narrow
        c = '1;                                             // every field at max
        c.last_candidate = 1'b0;
        offer(c);
        offer(model_box(0, 0, 300, 300, 40000, 1'b0));     // negative left edge
        offer(model_box(400, 100, 40, 40, 0, 1'b1));       // dropped last ends frame
        offer(model_box(50, 50, 40, 40, 0, 1'b1));         // empty frame
        offer(model_box(320, 320, 40, 40, 30000, 1'b1));   // single box
        c = '0;
        c.last_candidate = 1'b1;
        offer(c);                                           // all-zero last

        // extremes: max offsets and scale, widest frame, no threshold
        set_regs(4095, 4095, 24'hFFFFFF, 4095, 4095, 0, 65535);
        random_frames(20);
        // zero scale, one-pixel frame, max threshold, any overlap suppresses
        set_regs(0, 0, 0, 1, 1, 65535, 0);
        random_frames(12);
        // one-pixel frame at unit scale: clamp kills every box
        set_regs(0, 0, 65536, 1, 1, 0, 26214);
        random_frames(8);
        // overlap threshold zero at a sane scale
        set_regs(10, 20, 65536, 640, 480, 8000, 0);
        random_frames(25);

        for (int p = 0; p < 4; p++) begin
            set_regs($urandom_range(0, 200), $urandom_range(0, 200),
                     $urandom_range(32768, 131072),
                     ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(100, 2000),
                     $urandom_range(100, 2000),
                     $urandom_range(0, 40000),
                     ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
            random_frames(40);
        end

        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
